@@ rtl/bounded_euclidean_distance_unit_macros.svh @@
// Assertion macros shared by the bounded Euclidean distance RTL.
`ifndef BOUNDED_EUCLIDEAN_DISTANCE_UNIT_MACROS_SVH
`define BOUNDED_EUCLIDEAN_DISTANCE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bed_pkg.sv @@
// Types and constants of the bounded Euclidean distance unit.
package bed_pkg;

  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned ABS_W   = 16;
  localparam int unsigned BOUND_W = 21;
  localparam int unsigned MUL_W   = 21;
  localparam int unsigned SUM_W   = 42;
  localparam int unsigned ROOT_W  = 43;
  localparam int unsigned ALU_W   = 44;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_B,
    ST_MUL_D,
    ST_ACC,
    ST_CMP,
    ST_ROOT,
    ST_OUT
  } st_e;

  // Operations of the shared adder.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [ALU_W-1:0]   a;
    logic [ALU_W-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

endpackage

@@ rtl/bounded_euclidean_distance_unit.sv @@
// Top level of the bounded Euclidean distance unit: sequencer, state and ports.
//
// The block takes element pairs of two vectors on the input stream and returns one
// word per vector on the output stream. An input word carries the left and right
// elements and the bound; tuser marks the first pair of a vector and tlast the last.
// The bound is squared on the first pair; squared differences are summed until the
// sum passes the squared bound, after which further pairs of that vector are ignored.
// The last pair produces the sum, or its floor square root, with an exceeded flag.
// One shared multiplier and one shared 44-bit adder do the squaring, summing,
// compare and root arithmetic under a small sequencer. Each pair is squared, added
// and compared; a first pair first squares the bound on the multiplier. A last pair
// then loads the output register, after adder square-root steps when roots are on.
// The input is ready only while the sequencer is idle. Results sit in an output
// register, so the next vector streams in while a result waits; a stalled receiver
// only holds the block once a second result is ready to leave.
// Reset clears the sum, the squared bound, the stopped flag and skip_root (roots on).
// The APB register skip_root lies at address 0; write it only while the block is idle.
module bounded_euclidean_distance_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // left_element[15:0], right_element[31:16],
                                      // bound[52:32], zero padding[55:53]
  input  logic        s_axis_tlast,   // last_element
  input  logic [0:0]  s_axis_tuser,   // first_element
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // distance[41:0], zero padding[47:42]
  output logic [0:0]  m_axis_tuser,   // exceeded
  // APB configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SUM_W  = bed_pkg::SUM_W;
  localparam int unsigned ROOT_W = bed_pkg::ROOT_W;
  localparam int unsigned ALU_W  = bed_pkg::ALU_W;

  bed_pkg::st_e state_q, state_d;

  logic                        skip_root_q;
  logic [bed_pkg::ABS_W-1:0]   absd_q;
  logic [bed_pkg::BOUND_W-1:0] bound_q;
  logic                        first_q;
  logic                        last_q;
  logic [SUM_W-1:0]            sum_q;
  logic [SUM_W-1:0]            bsq_q;
  logic                        stopped_q;
  logic [ROOT_W-1:0]           res_q;
  logic [ROOT_W-1:0]           bit_q;
  logic                        m_valid_q;
  logic [SUM_W-1:0]            dist_q;
  logic                        exc_q;

  logic                        in_acc;
  logic                        out_load;
  logic signed [bed_pkg::ELEM_W:0] diff;
  logic [bed_pkg::ABS_W-1:0]   diff_abs;
  bed_pkg::alu_req_t           alu_req;
  bed_pkg::mul_req_t           mul_req;
  logic [ALU_W-1:0]            alu_res;
  logic [SUM_W-1:0]            prod;
  logic                        borrow;
  logic [ROOT_W-1:0]           trial;

  bed_alu u_alu (
    .req_i    (alu_req),
    .result_o (alu_res)
  );

  bed_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Handshakes.
  assign s_axis_tready = (state_q == bed_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == bed_pkg::ST_OUT) && (!m_valid_q || m_axis_tready);

  // Absolute difference of the incoming pair; it always fits in 16 bits.
  assign diff     = $signed({s_axis_tdata[15], s_axis_tdata[15:0]})
                  - $signed({s_axis_tdata[31], s_axis_tdata[31:16]});
  assign diff_abs = diff[16] ? 16'(-diff) : 16'(diff);

  assign borrow = alu_res[ALU_W-1];
  assign trial  = res_q | bit_q;

  // Next state and shared unit operands.
  always_comb begin
    state_d    = state_q;
    alu_req.op = bed_pkg::ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;
    mul_req.a  = bed_pkg::MUL_W'(absd_q);
    mul_req.b  = bed_pkg::MUL_W'(absd_q);
    unique case (state_q)
      bed_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = s_axis_tuser[0] ? bed_pkg::ST_MUL_B : bed_pkg::ST_MUL_D;
        end
      end
      bed_pkg::ST_MUL_B: begin
        mul_req.a = bound_q;
        mul_req.b = bound_q;
        state_d   = bed_pkg::ST_MUL_D;
      end
      bed_pkg::ST_MUL_D: begin
        state_d = bed_pkg::ST_ACC;
      end
      bed_pkg::ST_ACC: begin
        alu_req.op = bed_pkg::ALU_ADD;
        alu_req.a  = ALU_W'(sum_q);
        alu_req.b  = ALU_W'(prod);
        state_d    = bed_pkg::ST_CMP;
      end
      bed_pkg::ST_CMP: begin
        alu_req.op = bed_pkg::ALU_SUB;
        alu_req.a  = ALU_W'(bsq_q);
        alu_req.b  = ALU_W'(sum_q);
        if (!last_q) begin
          state_d = bed_pkg::ST_IDLE;
        end else if (skip_root_q) begin
          state_d = bed_pkg::ST_OUT;
        end else begin
          state_d = bed_pkg::ST_ROOT;
        end
      end
      bed_pkg::ST_ROOT: begin
        alu_req.op = bed_pkg::ALU_SUB;
        alu_req.a  = ALU_W'(sum_q);
        alu_req.b  = ALU_W'(trial);
        if (bit_q[0]) begin
          state_d = bed_pkg::ST_OUT;
        end
      end
      bed_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = bed_pkg::ST_IDLE;
        end
      end
      default: state_d = bed_pkg::ST_IDLE;
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bed_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_root_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      skip_root_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {31'd0, skip_root_q};

  // Captured input word.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      absd_q  <= diff_abs;
      bound_q <= s_axis_tdata[52:32];
      first_q <= s_axis_tuser[0];
      last_q  <= s_axis_tlast;
    end
  end

  // Running sum (also the root remainder), squared bound and stopped flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      bsq_q     <= '0;
      stopped_q <= 1'b0;
    end else begin
      unique case (state_q)
        bed_pkg::ST_IDLE: begin
          if (in_acc && s_axis_tuser[0]) begin
            sum_q     <= '0;
            stopped_q <= 1'b0;
          end
        end
        bed_pkg::ST_MUL_D: begin
          if (first_q) begin
            bsq_q <= prod;
          end
        end
        bed_pkg::ST_ACC: begin
          if (!stopped_q) begin
            // Saturate once the sum carries past 42 bits.
            sum_q <= alu_res[SUM_W] ? '1 : alu_res[SUM_W-1:0];
          end
        end
        bed_pkg::ST_CMP: begin
          if (!stopped_q && borrow) begin
            stopped_q <= 1'b1;
          end
        end
        bed_pkg::ST_ROOT: begin
          if (!borrow) begin
            sum_q <= alu_res[SUM_W-1:0];
          end
        end
        bed_pkg::ST_OUT: begin
          if (out_load) begin
            sum_q     <= '0;
            stopped_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Square root digit registers.
  always_ff @(posedge clk_i) begin
    if (state_q == bed_pkg::ST_CMP) begin
      res_q <= '0;
      bit_q <= ROOT_W'(1) << (ROOT_W - 1);
    end else if (state_q == bed_pkg::ST_ROOT) begin
      res_q <= borrow ? (res_q >> 1) : ((res_q >> 1) | bit_q);
      bit_q <= bit_q >> 2;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      dist_q <= skip_root_q ? sum_q : res_q[SUM_W-1:0];
      exc_q  <= stopped_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'd0, dist_q};
  assign m_axis_tuser  = exc_q;

  `include "bounded_euclidean_distance_unit_macros.svh"

  `BED_ASSERT_NEXT(a_first_squares_bound, in_acc && s_axis_tuser[0], state_q == bed_pkg::ST_MUL_B, "first pair did not square the bound")
  `BED_ASSERT_NOW(a_out_from_seq, $rose(m_axis_tvalid), $past(state_q == bed_pkg::ST_OUT), "result appeared outside the output step")
  `BED_ASSERT_NOW(a_root_bit_onehot, state_q == bed_pkg::ST_ROOT, $onehot(bit_q), "root trial bit lost its single set bit")
  `BED_ASSERT_NEXT(a_sum_within_bound, state_q == bed_pkg::ST_CMP && !stopped_q, stopped_q || sum_q <= bsq_q, "sum passed the bound without stopping")

endmodule

@@ rtl/bed_alu.sv @@
// Shared 44-bit add/subtract unit used for accumulate, compare and root steps.
module bed_alu (
  input  bed_pkg::alu_req_t              req_i,
  output logic [bed_pkg::ALU_W-1:0]      result_o
);

  // Subtraction leaves the borrow in the top bit.
  always_comb begin
    unique case (req_i.op)
      bed_pkg::ALU_ADD: result_o = req_i.a + req_i.b;
      bed_pkg::ALU_SUB: result_o = req_i.a - req_i.b;
      default:          result_o = req_i.a + req_i.b;
    endcase
  end

endmodule

@@ rtl/bed_mul.sv @@
// Shared 21x21 unsigned multiplier with a registered product.
module bed_mul (
  input  logic                           clk_i,
  input  bed_pkg::mul_req_t              req_i,
  output logic [bed_pkg::SUM_W-1:0]      prod_o
);

  logic [bed_pkg::SUM_W-1:0] prod_q;

  // Product register; payload only, so no reset.
  always_ff @(posedge clk_i) begin
    prod_q <= bed_pkg::SUM_W'(req_i.a) * bed_pkg::SUM_W'(req_i.b);
  end

  assign prod_o = prod_q;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the bounded Euclidean distance unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  REG_SKIP_ROOT = 3'd0;
  localparam logic [41:0] SUM_SAT       = {42{1'b1}};
  localparam logic [20:0] BOUND_MAX     = {21{1'b1}};
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STALL_LIMIT   = 2000;

  typedef struct packed {
    logic [41:0] distance;
    logic        exceeded;
  } dist_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // left_element[15:0], right_element[31:16],
                                    // bound[52:32], zero padding[55:53]
  logic        s_axis_tlast = 1'b0; // last_element
  logic [0:0]  s_axis_tuser = '0;   // first_element
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // distance[41:0], zero padding[47:42]
  logic [0:0]  m_axis_tuser;        // exceeded
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted state of the block.
  logic [41:0] sum_acc = '0;
  logic [41:0] bound_sq = '0;
  bit          halted = 1'b0;
  bit          root_off = 1'b0;

  dist_word_t  expected_q[$];
  int unsigned mismatches = 0;
  int unsigned pairs_sent = 0;
  bit          quiet = 1'b0;
  int unsigned rx_stall = 0;
  int unsigned idle_cycles = 0;

  bounded_euclidean_distance_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #6 clk_i = ~clk_i;

  // Gap length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Floor square root, one result bit at a time from the top.
  function automatic logic [41:0] floor_sqrt(input logic [41:0] v);
    logic [21:0] root;
    logic [21:0] trial;
    root = '0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (22'd1 << b);
      if (44'(trial) * 44'(trial) <= 44'(v)) root = trial;
    end
    return 42'(root);
  endfunction

  // Advance the predicted state by one accepted pair; a last pair yields a word.
  function automatic void predict_pair(input logic [15:0] l, input logic [15:0] r,
                                       input logic [20:0] bnd, input bit first,
                                       input bit last);
    logic [16:0] diff;
    logic [16:0] mag;
    logic [42:0] total;
    dist_word_t  word;
    if (first) begin
      sum_acc  = '0;
      halted   = 1'b0;
      bound_sq = 42'(bnd) * 42'(bnd);
    end
    if (!halted) begin
      diff  = {l[15], l} - {r[15], r};
      mag   = diff[16] ? -diff : diff;
      total = 43'(sum_acc) + 43'(34'(mag) * 34'(mag));
      sum_acc = total[42] ? SUM_SAT : total[41:0];
      if (sum_acc > bound_sq) halted = 1'b1;
    end
    if (last) begin
      word.distance = root_off ? sum_acc : floor_sqrt(sum_acc);
      word.exceeded = halted;
      expected_q.push_back(word);
      sum_acc = '0;
      halted  = 1'b0;
    end
  endfunction

  // Send one pair; tvalid stays high afterwards so back-to-back words need no gap.
  task automatic send_pair(input logic [15:0] l, input logic [15:0] r,
                           input logic [20:0] bnd, input bit first, input bit last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, bnd, r, l};
    s_axis_tlast  <= last;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pair(l, r, bnd, first, last);
    pairs_sent++;
  endtask

  // Hold the input off until every predicted word has come back.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  // Drain, then give a pair still in flight time to finish.
  task automatic drain_and_settle();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_skip_root(input bit value);
    drain_and_settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_SKIP_ROOT;
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    root_off = value;
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [15:0] random_elem();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return 16'($urandom);
    if (r < 75) return 16'($urandom_range(0, 127) - 64);
    if (r < 85) return 16'h7fff;
    if (r < 95) return 16'h8000;
    return 16'h0000;
  endfunction

  function automatic logic [20:0] random_bound();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return 21'($urandom);
    if (r < 45) return 21'($urandom_range(0, 300));
    if (r < 60) return 21'd0;
    if (r < 75) return BOUND_MAX;
    return 21'($urandom_range(0, 70000));
  endfunction

  // Extremes, zero bound, exact bound, crossing, missing and repeated first marks.
  task automatic test_directed_cases();
    // Missing first mark straight after reset: squared bound is still zero.
    send_pair(16'sd100, -16'sd100, 21'd7, 1'b0, 1'b1);
    // Zero bound with equal elements stays under the bound.
    send_pair(16'sd5, 16'sd5, 21'd0, 1'b1, 1'b1);
    // Zero bound, nonzero difference stops at once; the rest is ignored.
    send_pair(16'sd1, 16'sd0, 21'd0, 1'b1, 1'b0);
    send_pair(16'sh7fff, 16'sh8000, 21'd0, 1'b0, 1'b1);
    // Single-element vectors with the widest differences.
    send_pair(16'sh7fff, 16'sh8000, BOUND_MAX, 1'b1, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, BOUND_MAX, 1'b1, 1'b1);
    // Sum well under the bound.
    send_pair(16'sd10, 16'sd0, 21'd1000, 1'b1, 1'b0);
    send_pair(16'sd0, -16'sd20, 21'd0, 1'b0, 1'b0);
    send_pair(-16'sd30, 16'sd0, BOUND_MAX, 1'b0, 1'b1);
    // Sum lands exactly on the bound: not exceeded.
    send_pair(16'sd3, 16'sd0, 21'd5, 1'b1, 1'b0);
    send_pair(16'sd4, 16'sd0, 21'd5, 1'b0, 1'b1);
    // Crossing element is counted, later elements are not.
    send_pair(16'sd3, 16'sd0, 21'd5, 1'b1, 1'b0);
    send_pair(16'sd4, 16'sd0, 21'd5, 1'b0, 1'b0);
    send_pair(16'sd1, 16'sd0, 21'd5, 1'b0, 1'b0);
    send_pair(16'sd100, 16'sd0, 21'd5, 1'b0, 1'b0);
    send_pair(16'sd0, 16'sd0, 21'd5, 1'b0, 1'b1);
    // Missing first mark after a vector keeps the latched bound.
    send_pair(16'sd2, 16'sd0, 21'd0, 1'b0, 1'b0);
    send_pair(16'sd2, 16'sd1, 21'd0, 1'b0, 1'b1);
    // A second first mark restarts the vector with a new bound.
    send_pair(16'sd1, 16'sd0, 21'd10, 1'b1, 1'b0);
    send_pair(16'sd2, 16'sd0, 21'd3, 1'b1, 1'b1);
    // Zero vector.
    send_pair(16'sd0, 16'sd0, 21'd0, 1'b1, 1'b1);
  endtask

  // Squared output: extremes and a bound crossing.
  task automatic test_skip_root_setting();
    write_skip_root(1'b1);
    send_pair(16'sh7fff, 16'sh8000, BOUND_MAX, 1'b1, 1'b1);
    send_pair(-16'sd7, -16'sd7, 21'd0, 1'b1, 1'b1);
    send_pair(16'sd3, 16'sd0, 21'd4, 1'b1, 1'b0);
    send_pair(16'sd4, 16'sd0, 21'd4, 1'b0, 1'b0);
    send_pair(16'sd9, 16'sd0, 21'd4, 1'b0, 1'b1);
    write_skip_root(1'b0);
  endtask

  // More than a full vector of widest differences drives the sum into saturation.
  task automatic test_sum_saturation();
    write_skip_root(1'b1);
    for (int k = 0; k < 1025; k++) begin
      send_pair(16'sh7fff, 16'sh8000, BOUND_MAX, k == 0, 1'b0);
    end
    send_pair(16'sd0, 16'sd0, BOUND_MAX, 1'b0, 1'b1);
  endtask

  // Mostly well-formed vectors with random content, some broken framing.
  task automatic test_random_vectors(input int unsigned count);
    int unsigned start;
    int unsigned len;
    int unsigned mode;
    logic [20:0] bnd;
    bit          first;
    bit          last;
    start = pairs_sent;
    while (pairs_sent - start < count) begin
      mode = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      bnd  = random_bound();
      if ($urandom_range(0, 19) == 0) quiet = ~quiet;
      for (int k = 0; k < len; k++) begin
        first = (k == 0);
        last  = (k == len - 1);
        if (mode >= 80 && mode < 88) begin
          first = 1'b0;
        end else if (mode >= 88 && mode < 94) begin
          last = 1'b0;
        end else if (mode >= 94) begin
          first = ($urandom_range(0, 3) == 0);
          last  = ($urandom_range(0, 3) == 0);
        end
        send_pair(random_elem(), random_elem(), first ? bnd : 21'($urandom), first, last);
      end
      if ($urandom_range(0, 29) == 0) wait_for_results();
    end
    quiet = 1'b0;
  endtask

  // Receiver: random stalls, none while the quiet stretch is on.
  always @(posedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (rx_stall != 0) begin
      rx_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      rx_stall = pick_gap();
      m_axis_tready <= (rx_stall == 0);
      if (rx_stall != 0) rx_stall--;
    end
  end

  // Compare each accepted word with the oldest prediction.
  always @(posedge clk_i) begin
    dist_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected word, distance", m_axis_tdata[41:0], 0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[41:0] !== want.distance)
          report_mismatch("distance", m_axis_tdata[41:0], want.distance);
        if (m_axis_tuser[0] !== want.exceeded)
          report_mismatch("exceeded", m_axis_tuser[0], want.exceeded);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_skip_root_setting();
    test_sum_saturation();
    write_skip_root(1'b0);
    test_random_vectors(60);
    write_skip_root(1'b1);
    test_random_vectors(60);
    write_skip_root(1'b0);
    test_random_vectors(60);
    drain_and_settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
